// File: rtl/core/rmie_pkg.sv
// shared types, constants and field layout for the register-memory executor
package rmie_pkg;

    localparam int NUM_REGS   = 16;
    localparam int MEM_WORDS  = 16 * 1024;
    localparam int XLEN       = 32;
    localparam int RIDX_W     = 4;
    localparam int OP_W       = 4;
    localparam int WORD_SHIFT = $clog2(4);
    localparam int REG_AW     = $clog2(NUM_REGS);
    localparam int MEM_AW     = $clog2(MEM_WORDS);

    // slave-side tdata layout
    localparam int D_RD_LSB   = 0;
    localparam int D_RS1_LSB  = D_RD_LSB + RIDX_W;
    localparam int D_RS2_LSB  = D_RS1_LSB + RIDX_W;
    localparam int D_IMM_LSB  = D_RS2_LSB + RIDX_W;
    localparam int D_USE_BIT  = D_IMM_LSB + XLEN;
    localparam int D_PD_LSB   = D_USE_BIT + 1;
    localparam int S_DATA_W   = ((D_PD_LSB + XLEN + 7) / 8) * 8;
    localparam int S_USER_W   = OP_W;

    // master-side tdata: reg_write, written_reg, result_value, fault, dz, halted
    localparam int M_DATA_W   = 1 + RIDX_W + XLEN + 3;

    typedef enum logic [OP_W-1:0] {
        OP_SET  = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_LD   = 4'd5,
        OP_ST   = 4'd6,
        OP_RET  = 4'd7,
        OP_PRE  = 4'd8,
        OP_READ = 4'd9
    } t_op;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd_first;
        logic rd_second;
        logic cap_a;
        logic cap_b;
        logic exec;
        logic cap_div;
        logic cap_mem;
        logic wb;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_wait;
        logic mem_wait;
        logic div_done;
        logic out_free;
        logic halted;
    } t_dp_stat;

endpackage

// File: rtl/core/rmie_ram.sv
// generic single-write, single-read ram with registered read data
module rmie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/rmie_div.sv
// iterative signed 32-bit divider, one quotient bit per cycle, truncates toward zero
module rmie_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rmie_pkg::XLEN-1:0] i_dividend,
    input  logic [rmie_pkg::XLEN-1:0] i_divisor,
    output logic                      o_done,
    output logic [rmie_pkg::XLEN-1:0] o_quotient
);
    import rmie_pkg::*;

    localparam int CNT_W = $clog2(XLEN);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [XLEN-1:0]  r_rem;
    logic [XLEN-1:0]  r_quo;
    logic [XLEN-1:0]  r_dsr;
    logic             r_neg;

    logic [XLEN-1:0]  w_a_mag;
    logic [XLEN-1:0]  w_b_mag;
    logic [XLEN:0]    w_rem_sh;
    logic [XLEN:0]    w_diff;

    assign w_a_mag  = i_dividend[XLEN-1] ? (~i_dividend + XLEN'(1)) : i_dividend;
    assign w_b_mag  = i_divisor[XLEN-1] ? (~i_divisor + XLEN'(1)) : i_divisor;
    assign w_rem_sh = {r_rem, r_quo[XLEN-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(XLEN - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_a_mag;
            r_rem <= '0;
            r_dsr <= w_b_mag;
            r_neg <= i_dividend[XLEN-1] ^ i_divisor[XLEN-1];
        end else if (r_busy) begin
            // restoring step: keep the difference when it did not go negative
            if (!w_diff[XLEN]) begin
                r_rem <= w_diff[XLEN-1:0];
                r_quo <= {r_quo[XLEN-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[XLEN-1:0];
                r_quo <= {r_quo[XLEN-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + XLEN'(1)) : r_quo;

endmodule

// File: rtl/core/rmie_datapath.sv
// datapath: operand latches, register file, data memory, alu, divider and output register
module rmie_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rmie_pkg::t_dp_cmd             i_cmd,
    output rmie_pkg::t_dp_stat            o_stat,
    input  logic [rmie_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [rmie_pkg::S_USER_W-1:0] i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rmie_pkg::M_DATA_W-1:0] o_m_tdata
);
    import rmie_pkg::*;

    function automatic logic reg_in_range(input logic [RIDX_W-1:0] idx);
        return ({{(XLEN-RIDX_W){1'b0}}, idx} < XLEN'(NUM_REGS));
    endfunction

    // latched transaction
    logic [OP_W-1:0]   r_op;
    logic [RIDX_W-1:0] r_rd;
    logic [RIDX_W-1:0] r_rs1;
    logic [RIDX_W-1:0] r_rs2;
    logic [XLEN-1:0]   r_imm;
    logic              r_use_imm;
    logic [XLEN-1:0]   r_pdata;
    logic              r_ign;

    logic [XLEN-1:0]   r_a;
    logic [XLEN-1:0]   r_b;
    logic [XLEN-1:0]   r_res;
    logic              r_fault;
    logic              r_dz;
    logic              r_halt;
    logic              r_rd_ok;
    logic [NUM_REGS-1:0] r_rf_valid;
    logic [MEM_AW-1:0] r_clr_cnt;

    logic              r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic [OP_W-1:0]   w_in_op;
    logic              w_in_ign;

    logic w_set, w_add, w_sub, w_mul, w_div, w_ld, w_st, w_ret, w_pre, w_rdw;

    logic [XLEN-1:0]   w_bop;
    logic              w_bzero;
    logic [XLEN-1:0]   w_prod;
    logic [XLEN-1:0]   w_addr;
    logic [XLEN-WORD_SHIFT-1:0] w_word;
    logic              w_addr_bad;
    logic [MEM_AW-1:0] w_idx;
    logic              w_fault;
    logic [XLEN-1:0]   w_exec_res;

    logic [RIDX_W-1:0] w_rf_idx;
    logic [XLEN-1:0]   w_rf_rdata;
    logic [XLEN-1:0]   w_rf_val;
    logic              w_wr;
    logic [RIDX_W-1:0] w_wreg;
    logic              w_halt_next;

    logic              w_mem_we;
    logic [MEM_AW-1:0] w_mem_waddr;
    logic [XLEN-1:0]   w_mem_wdata;
    logic [XLEN-1:0]   w_mem_rdata;

    logic              w_div_start;
    logic              w_div_done;
    logic [XLEN-1:0]   w_quo;

    // ops up to ret are dropped once halted; unused codes always
    assign w_in_op  = i_s_tuser;
    assign w_in_ign = ((w_in_op <= OP_RET) && r_halt) || (w_in_op > OP_READ);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= w_in_op;
            r_ign     <= w_in_ign;
            r_rd      <= i_s_tdata[D_RD_LSB +: RIDX_W];
            r_rs1     <= i_s_tdata[D_RS1_LSB +: RIDX_W];
            r_rs2     <= i_s_tdata[D_RS2_LSB +: RIDX_W];
            r_imm     <= i_s_tdata[D_IMM_LSB +: XLEN];
            r_use_imm <= i_s_tdata[D_USE_BIT];
            r_pdata   <= i_s_tdata[D_PD_LSB +: XLEN];
        end
    end

    always_comb begin
        {w_set, w_add, w_sub, w_mul, w_div, w_ld, w_st, w_ret, w_pre, w_rdw} = '0;
        if (!r_ign) begin
            unique case (r_op)
                OP_SET:  w_set = 1'b1;
                OP_ADD:  w_add = 1'b1;
                OP_SUB:  w_sub = 1'b1;
                OP_MUL:  w_mul = 1'b1;
                OP_DIV:  w_div = 1'b1;
                OP_LD:   w_ld  = 1'b1;
                OP_ST:   w_st  = 1'b1;
                OP_RET:  w_ret = 1'b1;
                OP_PRE:  w_pre = 1'b1;
                OP_READ: w_rdw = 1'b1;
                default: ;
            endcase
        end
    end

    // register file reads: first source, then second source or store data
    assign w_rf_idx = i_cmd.rd_first ? r_rs1 : ((r_op == OP_ST) ? r_rd : r_rs2);
    assign w_rf_val = r_rd_ok ? w_rf_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_first || i_cmd.rd_second) begin
            r_rd_ok <= reg_in_range(w_rf_idx) && r_rf_valid[REG_AW'(w_rf_idx)];
        end
        if (i_cmd.cap_a) begin
            r_a <= w_rf_val;
        end
        if (i_cmd.cap_b) begin
            r_b <= w_rf_val;
        end
    end

    assign w_bop   = r_use_imm ? r_imm : r_b;
    assign w_bzero = (w_bop == '0);
    assign w_prod  = r_a * w_bop;

    // byte address to word index, bit 31 set counts as out of range
    assign w_addr     = (w_pre || w_rdw || r_use_imm) ? r_imm : r_a;
    assign w_word     = w_addr[XLEN-1:WORD_SHIFT];
    assign w_addr_bad = w_addr[XLEN-1] ||
                        ({{WORD_SHIFT{1'b0}}, w_word} >= XLEN'(MEM_WORDS));
    assign w_idx      = w_word[MEM_AW-1:0];
    assign w_fault    = (w_ld || w_st || w_pre || w_rdw) && w_addr_bad;

    always_comb begin
        w_exec_res = '0;
        if (w_set) begin
            w_exec_res = r_imm;
        end else if (w_add) begin
            w_exec_res = r_a + w_bop;
        end else if (w_sub) begin
            w_exec_res = r_a - w_bop;
        end else if (w_mul) begin
            w_exec_res = w_prod;
        end else if (w_st) begin
            w_exec_res = r_b;
        end else if (w_pre) begin
            w_exec_res = r_pdata;
        end
    end

    assign w_div_start = i_cmd.exec && w_div && !w_bzero;

    rmie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_a),
        .i_divisor  (w_bop),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res   <= w_exec_res;
            r_fault <= w_fault;
            r_dz    <= w_div && w_bzero;
        end else if (i_cmd.cap_div) begin
            r_res <= w_quo;
        end else if (i_cmd.cap_mem) begin
            r_res <= w_mem_rdata;
        end
    end

    // data memory, swept to zero after reset
    assign w_mem_we    = i_cmd.clr_wr || (i_cmd.exec && (w_st || w_pre) && !w_addr_bad);
    assign w_mem_waddr = i_cmd.clr_wr ? r_clr_cnt : w_idx;
    assign w_mem_wdata = i_cmd.clr_wr ? '0 : (w_st ? r_b : r_pdata);

    rmie_ram #(
        .WIDTH (XLEN),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_idx),
        .o_rdata (w_mem_rdata)
    );

    // write back
    assign w_wr        = (w_set || w_add || w_sub || w_mul || w_div || w_ld) &&
                         reg_in_range(r_rd);
    assign w_wreg      = w_wr ? r_rd : '0;
    assign w_halt_next = r_halt || w_ret;

    rmie_ram #(
        .WIDTH (XLEN),
        .DEPTH (NUM_REGS)
    ) u_rf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wb && w_wr),
        .i_waddr (REG_AW'(r_rd)),
        .i_wdata (r_res),
        .i_raddr (REG_AW'(w_rf_idx)),
        .o_rdata (w_rf_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid  <= '0;
            r_halt      <= 1'b0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + MEM_AW'(1);
            end
            if (i_cmd.wb) begin
                if (w_wr) begin
                    r_rf_valid[REG_AW'(r_rd)] <= 1'b1;
                end
                r_halt      <= w_halt_next;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_out_data <= {w_halt_next, r_dz, r_fault, r_res, w_wreg, w_wr};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign o_stat.clr_last = (r_clr_cnt == MEM_AW'(MEM_WORDS - 1));
    assign o_stat.div_wait = w_div && !w_bzero;
    assign o_stat.mem_wait = (w_ld || w_rdw) && !w_addr_bad;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_stat.halted   = r_halt;

endmodule

// File: rtl/core/rmie_ctrl.sv
// controller state machine sequencing each transaction through the datapath
module rmie_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  rmie_pkg::t_dp_stat i_stat,
    output rmie_pkg::t_dp_cmd  o_cmd
);
    import rmie_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD1   = 9'b000000100,
        S_RD2   = 9'b000001000,
        S_RD3   = 9'b000010000,
        S_EXEC  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_MEM   = 9'b010000000,
        S_WB    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd_first = 1'b1;
                n_state        = S_RD2;
            end
            S_RD2: begin
                o_cmd.cap_a     = 1'b1;
                o_cmd.rd_second = 1'b1;
                n_state         = S_RD3;
            end
            S_RD3: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.div_wait) begin
                    n_state = S_DIV;
                end else if (i_stat.mem_wait) begin
                    n_state = S_MEM;
                end else begin
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_div = 1'b1;
                    n_state       = S_WB;
                end
            end
            S_MEM: begin
                o_cmd.cap_mem = 1'b1;
                n_state       = S_WB;
            end
            S_WB: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.wb = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

// File: rtl/core/register_memory_isa_executor_core.sv
// Executes one decoded instruction per transaction against a 16 x 32-bit register
// file and a 16384-word data memory. After reset the data memory is swept to zero,
// one word per cycle, and no transaction is accepted until the sweep ends.
// Transactions are handled one at a time: register-file reads, an execute state
// and write back, with a memory read state for ld and read at a valid address
// and a divide state for div with a nonzero divisor, in which the divider
// produces one quotient bit per cycle. The result sits in an output register, so
// the next transaction is accepted while it waits; only write back stalls on a
// full output.
module register_memory_isa_executor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // dest_reg[3:0], src1_reg[7:4], src2_reg[11:8], imm_value[43:12], use_imm[44],
    // preload_data[76:45], zero[79:77]
    input  logic [rmie_pkg::S_DATA_W-1:0] s_axis_tdata,
    // req_type[3:0]
    input  logic [rmie_pkg::S_USER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // reg_write[0], written_reg[4:1], result_value[36:5], address_fault[37],
    // divide_by_zero[38], halted[39]
    output logic [rmie_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import rmie_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rmie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rmie_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    // one transaction in flight: ready drops right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("transaction accepted while another is in flight");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(w_stat.halted))
        else $error("halt flag cleared without reset");

    // the pending result reports the current halt state
    a_halt_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39] == w_stat.halted))
        else $error("halted bit disagrees with halt flag");

    // no register written means index zero, and a fault never pairs with divide by zero
    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[0] || (m_axis_tdata[4:1] == '0)) &&
                           !(m_axis_tdata[37] && m_axis_tdata[38])))
        else $error("inconsistent result flags");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the register-memory instruction executor core
module tb_top;
    import rmie_pkg::*;

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_W'(OP_READ + 1);
    localparam logic [OP_W-1:0] OP_LAST_CODE    = '1;
    localparam logic [XLEN-1:0] INT_MAX         = 32'h7FFF_FFFF;
    localparam logic [XLEN-1:0] INT_MIN         = 32'h8000_0000;
    localparam logic [XLEN-1:0] TOP_BYTE        = (MEM_WORDS << WORD_SHIFT) - 1;
    localparam logic [XLEN-1:0] PAST_END        = MEM_WORDS << WORD_SHIFT;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [RIDX_W-1:0] rd;
        logic [RIDX_W-1:0] rs1;
        logic [RIDX_W-1:0] rs2;
        logic [XLEN-1:0]   imm;
        logic              use_imm;
        logic [XLEN-1:0]   pdata;
    } t_instr;

    // same bit order as the result tdata, msb first
    typedef struct packed {
        logic              halted;
        logic              div_zero;
        logic              fault;
        logic [XLEN-1:0]   value;
        logic [RIDX_W-1:0] wreg;
        logic              reg_write;
    } t_outcome;

    class exec_tracker;
        bit [XLEN-1:0] regs [NUM_REGS];
        bit [XLEN-1:0] mem [MEM_WORDS];
        bit            halted;
        t_outcome      expected_outcomes[$];
        int            errors;

        function bit word_ok(logic [XLEN-1:0] addr);
            return !addr[XLEN-1] && (addr >> WORD_SHIFT) < MEM_WORDS;
        endfunction

        function void accept_instr(t_instr ins);
            t_outcome      o;
            logic [XLEN-1:0] a, b, addr, val;
            longint        quo;
            o = '0;
            val = '0;
            if (halted && ins.op <= OP_RET) begin
                o.halted = 1'b1;
                expected_outcomes.push_back(o);
                return;
            end
            a = regs[ins.rs1];
            b = ins.use_imm ? ins.imm : regs[ins.rs2];
            addr = ins.use_imm ? ins.imm : regs[ins.rs1];
            case (ins.op)
                OP_SET, OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    case (ins.op)
                        OP_SET: val = ins.imm;
                        OP_ADD: val = a + b;
                        OP_SUB: val = a - b;
                        OP_MUL: val = a * b;
                        default: begin
                            if (b == '0) begin
                                o.div_zero = 1'b1;
                            end else begin
                                // 64-bit quotient so most-negative / -1 wraps cleanly
                                quo = longint'($signed(a)) / longint'($signed(b));
                                val = quo[XLEN-1:0];
                            end
                        end
                    endcase
                    regs[ins.rd] = val;
                    o.reg_write = 1'b1;
                    o.wreg = ins.rd;
                end
                OP_LD: begin
                    if (word_ok(addr)) val = mem[addr[WORD_SHIFT +: MEM_AW]];
                    else o.fault = 1'b1;
                    regs[ins.rd] = val;
                    o.reg_write = 1'b1;
                    o.wreg = ins.rd;
                end
                OP_ST: begin
                    val = regs[ins.rd];
                    if (word_ok(addr)) mem[addr[WORD_SHIFT +: MEM_AW]] = val;
                    else o.fault = 1'b1;
                end
                OP_RET: halted = 1'b1;
                OP_PRE: begin
                    val = ins.pdata;
                    if (word_ok(ins.imm)) mem[ins.imm[WORD_SHIFT +: MEM_AW]] = val;
                    else o.fault = 1'b1;
                end
                OP_READ: begin
                    if (word_ok(ins.imm)) val = mem[ins.imm[WORD_SHIFT +: MEM_AW]];
                    else o.fault = 1'b1;
                end
                default: ;
            endcase
            o.value = val;
            o.halted = halted;
            expected_outcomes.push_back(o);
        endfunction

        function void compare_field(string name, logic [XLEN-1:0] want,
                                    logic [XLEN-1:0] seen);
            if (seen !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_outcome(logic [M_DATA_W-1:0] raw);
            t_outcome got, want;
            got = raw;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result %h", $time, raw);
                errors++;
                return;
            end
            want = expected_outcomes.pop_front();
            compare_field("reg_write", XLEN'(want.reg_write), XLEN'(got.reg_write));
            compare_field("written_reg", XLEN'(want.wreg), XLEN'(got.wreg));
            compare_field("result_value", want.value, got.value);
            compare_field("address_fault", XLEN'(want.fault), XLEN'(got.fault));
            compare_field("divide_by_zero", XLEN'(want.div_zero), XLEN'(got.div_zero));
            compare_field("halted", XLEN'(want.halted), XLEN'(got.halted));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic [S_USER_W-1:0]   s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    bit                    steady_phase = 1'b0;

    exec_tracker tracker = new();

    register_memory_isa_executor_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= steady_phase || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) tracker.check_outcome(m_axis_tdata);
    end

    function automatic t_instr mk(logic [OP_W-1:0] op, logic [RIDX_W-1:0] rd,
                                  logic [RIDX_W-1:0] rs1, logic [RIDX_W-1:0] rs2,
                                  logic [XLEN-1:0] imm, logic use_imm,
                                  logic [XLEN-1:0] pdata);
        t_instr ins;
        ins.op = op;
        ins.rd = rd;
        ins.rs1 = rs1;
        ins.rs2 = rs2;
        ins.imm = imm;
        ins.use_imm = use_imm;
        ins.pdata = pdata;
        return ins;
    endfunction

    function automatic logic [XLEN-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return INT_MIN;
            4: return INT_MAX;
            5: return $urandom_range(0, 200) - 100;
            default: return $urandom();
        endcase
    endfunction

    // mostly a small window of words so loads see earlier stores
    function automatic logic [XLEN-1:0] rand_addr();
        int pick = $urandom_range(0, 9);
        if (pick < 7)
            return ($urandom_range(0, 31) << WORD_SHIFT) | $urandom_range(0, 3);
        else if (pick == 7)
            return TOP_BYTE - $urandom_range(0, 15);
        else if (pick == 8)
            return $urandom_range(PAST_END, INT_MAX);
        else
            return INT_MIN | $urandom();
    endfunction

    function automatic t_instr rand_instr();
        t_instr ins;
        int     pick;
        ins.rd = RIDX_W'($urandom_range(0, 15));
        ins.rs1 = RIDX_W'($urandom_range(0, 15));
        ins.rs2 = RIDX_W'($urandom_range(0, 15));
        ins.use_imm = 1'($urandom_range(0, 1));
        ins.imm = rand_value();
        ins.pdata = rand_value();
        pick = $urandom_range(0, 99);
        if (pick < 12) ins.op = OP_SET;
        else if (pick < 20) ins.op = OP_ADD;
        else if (pick < 28) ins.op = OP_SUB;
        else if (pick < 36) ins.op = OP_MUL;
        else if (pick < 46) ins.op = OP_DIV;
        else if (pick < 60) ins.op = OP_LD;
        else if (pick < 74) ins.op = OP_ST;
        else if (pick < 85) ins.op = OP_PRE;
        else if (pick < 96) ins.op = OP_READ;
        else ins.op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
        if (ins.op == OP_PRE || ins.op == OP_READ
            || ((ins.op == OP_LD || ins.op == OP_ST) && ins.use_imm))
            ins.imm = rand_addr();
        return ins;
    endfunction

    task automatic send_instr(t_instr ins);
        logic [S_DATA_W-1:0] word;
        int                  gap;
        gap = (!steady_phase && $urandom_range(0, 99) < 16) ? $urandom_range(1, 4) : 0;
        word = '0;
        word[D_RD_LSB +: RIDX_W] = ins.rd;
        word[D_RS1_LSB +: RIDX_W] = ins.rs1;
        word[D_RS2_LSB +: RIDX_W] = ins.rs2;
        word[D_IMM_LSB +: XLEN] = ins.imm;
        word[D_USE_BIT] = ins.use_imm;
        word[D_PD_LSB +: XLEN] = ins.pdata;
        @(negedge i_clk);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= ins.op;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.accept_instr(ins);
    endtask

    initial begin
        t_instr ins;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // operand extremes, wraps and the divider corner cases
        send_instr(mk(OP_SET, 4'd1, 4'd15, 4'd15, INT_MAX, 1'b1, '1));
        send_instr(mk(OP_SET, 4'd2, 4'd0, 4'd0, INT_MIN, 1'b0, '0));
        send_instr(mk(OP_SET, 4'd3, 4'd0, 4'd0, '1, 1'b1, '0));
        send_instr(mk(OP_ADD, 4'd4, 4'd1, 4'd0, 32'd1, 1'b1, '0));
        send_instr(mk(OP_SUB, 4'd5, 4'd2, 4'd3, '0, 1'b0, '0));
        send_instr(mk(OP_MUL, 4'd6, 4'd1, 4'd1, '0, 1'b0, '0));
        send_instr(mk(OP_DIV, 4'd7, 4'd2, 4'd3, '0, 1'b0, '0));
        send_instr(mk(OP_DIV, 4'd8, 4'd1, 4'd0, '0, 1'b0, '0));
        send_instr(mk(OP_DIV, 4'd9, 4'd3, 4'd0, '0, 1'b1, '0));
        send_instr(mk(OP_DIV, 4'd10, 4'd2, 4'd0, 32'd7, 1'b1, '0));
        // memory: both ends, past the end, negative addresses
        send_instr(mk(OP_PRE, 4'd0, 4'd0, 4'd0, 32'd0, 1'b1, 32'h5A5A_A5A5));
        send_instr(mk(OP_PRE, 4'd0, 4'd0, 4'd0, TOP_BYTE, 1'b0, INT_MIN));
        send_instr(mk(OP_PRE, 4'd0, 4'd0, 4'd0, PAST_END, 1'b0, INT_MAX));
        send_instr(mk(OP_PRE, 4'd0, 4'd0, 4'd0, '1, 1'b0, 32'h1234_5678));
        send_instr(mk(OP_READ, 4'd0, 4'd0, 4'd0, TOP_BYTE - 3, 1'b0, '0));
        send_instr(mk(OP_READ, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFD, 1'b0, '0));
        send_instr(mk(OP_LD, 4'd11, 4'd0, 4'd0, 32'd2, 1'b1, '0));
        send_instr(mk(OP_LD, 4'd12, 4'd0, 4'd0, PAST_END, 1'b1, '0));
        send_instr(mk(OP_LD, 4'd12, 4'd0, 4'd0, 32'h7FFF_FFFC, 1'b1, '0));
        send_instr(mk(OP_ST, 4'd1, 4'd0, 4'd0, 32'd8, 1'b1, '0));
        send_instr(mk(OP_SET, 4'd13, 4'd0, 4'd0, 32'd9, 1'b1, '0));
        send_instr(mk(OP_LD, 4'd14, 4'd13, 4'd0, '0, 1'b0, '0));
        send_instr(mk(OP_ST, 4'd2, 4'd3, 4'd0, '0, 1'b0, '0));
        send_instr(mk(OP_READ, 4'd0, 4'd0, 4'd0, 32'd8, 1'b0, '0));
        send_instr(mk(OP_FIRST_UNUSED, 4'd5, 4'd1, 4'd2, '1, 1'b1, '1));
        send_instr(mk(OP_LAST_CODE, 4'd5, 4'd1, 4'd2, '1, 1'b0, '1));

        for (int n = 0; n < 780; n++) begin
            steady_phase = (n >= 300 && n < 450);
            ins = rand_instr();
            // register-addressed accesses mostly get an address, usually valid, set up first
            if ((ins.op == OP_LD || ins.op == OP_ST) && !ins.use_imm
                && $urandom_range(0, 9) < 7)
                send_instr(mk(OP_SET, ins.rs1, 4'd0, 4'd0, rand_addr(), 1'b1, $urandom()));
            send_instr(ins);
        end
        steady_phase = 1'b0;

        // ret is final: everything after it runs in the halted state
        send_instr(mk(OP_RET, 4'd0, 4'd0, 4'd0, '0, 1'b0, '0));
        for (int k = int'(OP_SET); k <= int'(OP_RET); k++)
            send_instr(mk(OP_W'(k), 4'd3, 4'd1, 4'd2, 32'd4, 1'b1, 32'd77));
        send_instr(mk(OP_PRE, 4'd0, 4'd0, 4'd0, 32'd12, 1'b1, 32'hCAFE_0001));
        send_instr(mk(OP_READ, 4'd0, 4'd0, 4'd0, 32'd12, 1'b1, '0));
        send_instr(mk(OP_FIRST_UNUSED, 4'd0, 4'd0, 4'd0, '0, 1'b0, '0));
        repeat (20) send_instr(rand_instr());

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.expected_outcomes.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // time limit for the memory sweep after reset plus ~950 transactions
    initial begin
        #3_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
